// File: sv/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

	// Width of one packed decimal digit.
	localparam int DIGIT_W = 4;

	// Width of one emitted character.
	localparam int CHAR_W = 6;

	// Most shift-and-add-3 steps done by one pipeline stage.
	localparam int STAGE_STEPS = 8;

	// A digit at or above this value is corrected before the next shift.
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;

	// Correction added to such a digit.
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ = 4'd3;

	// ASCII code of the character '0', cut to the character width.
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

endpackage

// File: sv/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  value (VALUE_BITS, signed)
// output    out        out_valid/out_stall  digit_char (6), last_digit (1)
//
// The conversion pipeline takes one transaction per cycle unless stalled,
// through ceil((VALUE_BITS-1)/8) shift-and-add-3 stages of up to eight bit
// steps each. The single output register gives one digit per cycle unless
// stalled; an item gives max(1, digit count) digits, its first digit passing
// the stage registers, digit store and output register. Reset clears all
// valid bits. Full stages wait behind held ones; nothing drops or repeats.

module binary_to_decimal_ascii #(
	parameter int MAX_DIGITS = 10,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [b2da_pkg::CHAR_W-1:0]  digit_char,
	output logic                         last_digit
);

	localparam int MAG_BITS   = VALUE_BITS - 1;
	localparam int BCD_DIGITS = (MAG_BITS * 30103) / 100000 + 1;
	localparam int BCD_W      = BCD_DIGITS * b2da_pkg::DIGIT_W;
	localparam int NUM_STAGES = (MAG_BITS + b2da_pkg::STAGE_STEPS - 1) / b2da_pkg::STAGE_STEPS;

	logic [NUM_STAGES:0]               v_w;
	logic [NUM_STAGES:0]               st_w;
	logic [NUM_STAGES:0][BCD_W-1:0]    bcd_w;
	logic [NUM_STAGES:0][MAG_BITS-1:0] bin_w;

	// Negative values convert as zero.
	assign v_w[0]   = in_valid;
	assign in_stall = st_w[0];
	assign bcd_w[0] = '0;
	assign bin_w[0] = value[VALUE_BITS-1] ? '0 : value[MAG_BITS-1:0];

	// Shift-and-add-3 pipeline.
	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
		localparam int LEFT  = MAG_BITS - g * b2da_pkg::STAGE_STEPS;
		localparam int STEPS = (LEFT < b2da_pkg::STAGE_STEPS) ? LEFT : b2da_pkg::STAGE_STEPS;

		b2da_dabble_stage #(
			.BCD_DIGITS (BCD_DIGITS),
			.MAG_BITS   (MAG_BITS),
			.STEPS      (STEPS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_w[g]),
			.in_stall  (st_w[g]),
			.in_bcd    (bcd_w[g]),
			.in_bin    (bin_w[g]),
			.out_valid (v_w[g+1]),
			.out_stall (st_w[g+1]),
			.out_bcd   (bcd_w[g+1]),
			.out_bin   (bin_w[g+1])
		);
	end

	// Digit emission.
	b2da_serializer #(
		.BCD_DIGITS (BCD_DIGITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_w[NUM_STAGES]),
		.in_stall   (st_w[NUM_STAGES]),
		.in_bcd     (bcd_w[NUM_STAGES]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	// A run of digits continues without a gap until its last digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_digit |=> out_valid)
		else $error("digit run broken before its last digit");

	// Only decimal digit characters leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
		else $error("non-digit character emitted");

	// The input is held back only while the first stage holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_w[1])
		else $error("input stalled with an empty first stage");

endmodule

// File: sv/b2da_dabble_stage.sv
`timescale 1ns / 1ps

module b2da_dabble_stage #(
	parameter int BCD_DIGITS = 10,
	parameter int MAG_BITS = 31,
	parameter int STEPS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [BCD_DIGITS*b2da_pkg::DIGIT_W-1:0]  in_bcd,
	input  logic [MAG_BITS-1:0]                      in_bin,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [BCD_DIGITS*b2da_pkg::DIGIT_W-1:0]  out_bcd,
	output logic [MAG_BITS-1:0]                      out_bin
);

	localparam int BCD_W = BCD_DIGITS * b2da_pkg::DIGIT_W;

	logic             valid_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [MAG_BITS-1:0] bin_s1;
	logic [BCD_W-1:0] bcd_next;
	logic [MAG_BITS-1:0] bin_next;
	logic             advance;

	// The stage register moves when it is empty or its content is taken.
	assign advance  = !valid_s1 || !out_stall;
	assign in_stall = !advance;

	// Several shift-and-add-3 steps: correct each digit >= 5, then shift one bit in.
	always_comb begin
		bcd_next = in_bcd;
		bin_next = in_bin;
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (bcd_next[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::DIGIT_ADJ_MIN) begin
					bcd_next[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
						bcd_next[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DIGIT_ADJ;
				end
			end
			{bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Data of the stage.
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			bcd_s1 <= bcd_next;
			bin_s1 <= bin_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_bcd   = bcd_s1;
	assign out_bin   = bin_s1;

endmodule

// File: sv/b2da_serializer.sv
`timescale 1ns / 1ps

module b2da_serializer #(
	parameter int BCD_DIGITS = 10,
	parameter int MAX_DIGITS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [BCD_DIGITS*b2da_pkg::DIGIT_W-1:0]  in_bcd,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [b2da_pkg::CHAR_W-1:0]              digit_char,
	output logic                                     last_digit
);

	localparam int IDX_W = (BCD_DIGITS > 1) ? $clog2(BCD_DIGITS) : 1;
	localparam int LIMIT = ((MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS) - 1;

	logic [BCD_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] bcd_q;
	logic [IDX_W-1:0]                             idx_q;
	logic                                         busy_q;
	logic                                         out_valid_q;
	logic [b2da_pkg::CHAR_W-1:0]                  digit_char_q;
	logic                                         last_digit_q;
	logic [IDX_W-1:0]                             start_idx;
	logic                                         advance;
	logic                                         accept;
	logic                                         final_digit;
	logic [b2da_pkg::DIGIT_W-1:0]                 cur_digit;

	// The output register moves when it is empty or its transaction completes.
	assign advance     = !out_valid_q || !out_stall;
	assign final_digit = (idx_q == '0);
	assign in_stall    = busy_q && !(advance && final_digit);
	assign accept      = in_valid && !in_stall;
	assign cur_digit   = bcd_q[idx_q];

	// Position of the leading digit, held to the digit limit; zero gives one '0'.
	always_comb begin
		start_idx = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (in_bcd[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] != '0) begin
				start_idx = IDX_W'((i > LIMIT) ? LIMIT : i);
			end
		end
	end

	// Control: busy while digits of the held item remain, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (advance && busy_q && final_digit) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Digit store and the digit pointer, counting down to the last digit.
	always_ff @(posedge clk) begin
		if (accept) begin
			bcd_q <= in_bcd;
			idx_q <= start_idx;
		end else if (advance && busy_q && !final_digit) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			digit_char_q <= b2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
			last_digit_q <= final_digit;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last_digit = last_digit_q;

endmodule

// File: verif/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;

	localparam int MAX_DIGITS = 10;
	localparam int VALUE_BITS = 32;
	localparam int RADIX = 10;
	localparam int STUCK_LIMIT = 3000;
	localparam int HOLD_CYCLES = 250;
	localparam int TAIL_CYCLES = 40;
	localparam int CHAR_W = b2da_pkg::CHAR_W;

	// One expected output character and its end-of-number flag.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	localparam logic signed [VALUE_BITS-1:0] DIRECTED [18] = '{
		32'sd0, 32'sd1, 32'sd9, 32'sd10, 32'sd99, 32'sd100, 32'sd7,
		32'shFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1000000000,
		32'sd999999999, 32'sd1234567890, 32'sh5555_5555, 32'sh2AAA_AAAA,
		32'shAAAA_AAAA, 32'sd4294967, 32'sd1000000001
	};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [CHAR_W-1:0]            digit_char;
	logic                         last_digit;

	logic signed [VALUE_BITS-1:0] pending_values [$];
	digit_t                       digits_due [$];
	bit                           in_taken = 1'b0;
	int                           send_idle_pct = 0;
	int                           recv_idle_pct = 0;
	int                           hold_req = 0;
	int                           hold_done = 0;
	int                           hold_left = 0;
	int                           err_count = 0;
	int                           stuck_cycles = 0;

	binary_to_decimal_ascii #(
		.MAX_DIGITS(MAX_DIGITS),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Work out the characters of one number and queue them, most significant first.
	function automatic void predict_digits(input logic signed [VALUE_BITS-1:0] v);
		longint unsigned mag;
		int              nd;
		logic [3:0]      dig [MAX_DIGITS];
		digit_t          d;
		mag = v[VALUE_BITS-1] ? 0 : longint'(unsigned'(v));
		nd = 0;
		while (mag > 0 && nd < MAX_DIGITS) begin
			dig[nd] = 4'(mag % RADIX);
			mag = mag / RADIX;
			nd++;
		end
		if (nd == 0) begin
			d.ch = b2da_pkg::ASCII_ZERO;
			d.last = 1'b1;
			digits_due.push_back(d);
		end else begin
			for (int k = nd - 1; k >= 0; k--) begin
				d.ch = CHAR_W'(dig[k] + b2da_pkg::ASCII_ZERO);
				d.last = (k == 0);
				digits_due.push_back(d);
			end
		end
	endfunction

	// Random number: full range, negatives, zero or one, or a chosen digit count.
	function automatic logic signed [VALUE_BITS-1:0] random_value();
		int unsigned     kind;
		int unsigned     nd;
		longint unsigned lo;
		longint unsigned hi;
		kind = $urandom_range(9);
		if (kind < 2)
			return $urandom;
		if (kind == 2)
			return {1'b1, 31'($urandom)};
		if (kind == 3)
			return $urandom_range(1);
		nd = $urandom_range(10, 1);
		lo = 1;
		for (int i = 1; i < nd; i++)
			lo = lo * RADIX;
		hi = lo * RADIX - 1;
		if (hi > 64'h7FFF_FFFF)
			hi = 64'h7FFF_FFFF;
		return $urandom_range(32'(hi), 32'(lo));
	endfunction

	// Wait until every queued number has been sent and every character has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_values.size() != 0 || in_valid || digits_due.size() != 0);
		@(posedge clk);
	endtask

	task automatic play_phase(input int send_pct, input int recv_pct, input int n_items);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < n_items; i++)
			pending_values.push_back(random_value());
		wait_drained();
	endtask

	// Input driver: offers queued numbers and holds a transaction until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					value <= pending_values.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output receiver: random back-pressure, plus long hold-offs on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_done != hold_req) begin
				hold_done = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Monitor: predicts on each input transaction and checks each output transaction.
	always @(posedge clk) begin
		digit_t exp_d;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken)
			predict_digits(value);
		if (arst_n && out_valid && !out_stall) begin
			if (digits_due.size() == 0) begin
				$error("unexpected output: digit_char=%0d last_digit=%0d",
					digit_char, last_digit);
				err_count++;
			end else begin
				exp_d = digits_due.pop_front();
				if (digit_char !== exp_d.ch) begin
					$error("digit_char: expected %0d, got %0d", exp_d.ch, digit_char);
					err_count++;
				end
				if (last_digit !== exp_d.last) begin
					$error("last_digit: expected %0d, got %0d", exp_d.last, last_digit);
					err_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed corner values.
		send_idle_pct = 29;
		recv_idle_pct = 82;
		foreach (DIRECTED[i])
			pending_values.push_back(DIRECTED[i]);
		wait_drained();

		// Random traffic under the three idle mixes.
		play_phase(29, 82, 60);
		play_phase(82, 29, 60);
		play_phase(0, 0, 50);

		// Long receiver hold-off while the sender keeps offering numbers.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req++;
		for (int i = 0; i < 40; i++)
			pending_values.push_back(random_value());
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (digits_due.size() != 0) begin
			$error("%0d expected characters never arrived", digits_due.size());
			err_count++;
		end
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
